[rtl/rmle_pkg.sv]
// Package for the remote monitor link engine.
// Holds item codes, command codes, phases and the decoded-item struct; no dependencies.
package rmle_pkg;

    localparam logic [1:0] FUNC_RX   = 2'd0;
    localparam logic [1:0] FUNC_PULL = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [2:0] ST_PASS   = 3'd0;
    localparam logic [2:0] ST_ABSORB = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_RESUME = 3'd3;
    localparam logic [2:0] ST_TXBYTE = 3'd4;
    localparam logic [2:0] ST_TXIDLE = 3'd5;
    localparam logic [2:0] ST_TICKOK = 3'd6;
    localparam logic [2:0] ST_TIMEOUT = 3'd7;

    localparam logic [7:0] CMD_CANCEL  = 8'h01;
    localparam logic [7:0] CMD_SLEEP   = 8'h02;
    localparam logic [7:0] CMD_OFFSET  = 8'h03;
    localparam logic [7:0] CMD_SEGMENT = 8'h04;
    localparam logic [7:0] CMD_LEN_LO  = 8'h05;
    localparam logic [7:0] CMD_BLK_WR  = 8'h06;
    localparam logic [7:0] CMD_BLK_RD  = 8'h07;
    localparam logic [7:0] CMD_LEN_HI  = 8'h08;
    localparam logic [7:0] CMD_RD_BYTE = 8'h0c;
    localparam logic [7:0] CMD_RD_WORD = 8'h0d;
    localparam logic [7:0] CMD_WR_BYTE = 8'h0e;
    localparam logic [7:0] CMD_WR_WORD = 8'h0f;
    localparam logic [7:0] CMD_DUMMY   = 8'h10;
    localparam logic [7:0] CMD_SUM     = 8'h16;
    localparam logic [7:0] HOT_BREAK   = 8'h14;
    localparam logic [7:0] BYTE_OPEN   = 8'h00;
    localparam logic [7:0] BYTE_RESUME = 8'h01;

    localparam logic [2:0] RX_IDLE = 3'd0;
    localparam logic [2:0] RX_CMD  = 3'd1;
    localparam logic [2:0] RX_PLO  = 3'd2;
    localparam logic [2:0] RX_PHI  = 3'd3;
    localparam logic [2:0] RX_BLK  = 3'd4;

    localparam logic [1:0] TX_IDLE = 2'd0;
    localparam logic [1:0] TX_LEAD = 2'd1;
    localparam logic [1:0] TX_DATA = 2'd2;

    localparam logic [1:0] CFG_SLEEP   = 2'd0;
    localparam logic [1:0] CFG_SEGMENT = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    typedef enum logic [3:0] {
        OP_RX   = 4'b0001,
        OP_PULL = 4'b0010,
        OP_TICK = 4'b0100,
        OP_NONE = 4'b1000
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       channel;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] value;
    } result_t;

endpackage

[rtl/rmle_if.sv]
// Valid/ready channel interfaces for the remote monitor link engine.
// Depends on nothing but plain logic types.
interface rmle_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       channel;
    logic [7:0] rx_byte;
    modport source (output valid, func, channel, rx_byte, input ready);
    modport sink (input valid, func, channel, rx_byte, output ready);
endinterface

interface rmle_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] value;
    modport source (output valid, status, value, input ready);
    modport sink (input valid, status, value, output ready);
endinterface

interface rmle_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/rmle_front.sv]
// Front part: accepts input items, classifies them and queues them for the back part.
// Depends on rmle_pkg and rmle_in_if.
module rmle_front #(
    parameter int CHANNELS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    rmle_in_if.sink           in_ch,
    output rmle_pkg::item_t   q_item,
    output logic              q_valid,
    input  logic              q_pop
);
    localparam int DEPTH = 2;

    rmle_pkg::item_t fifo_reg [DEPTH];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;
    rmle_pkg::item_t cls;
    logic            push;

    always_comb
    begin
        case (in_ch.func)
            rmle_pkg::FUNC_RX:   cls.op = rmle_pkg::OP_RX;
            rmle_pkg::FUNC_PULL: cls.op = rmle_pkg::OP_PULL;
            rmle_pkg::FUNC_TICK: cls.op = rmle_pkg::OP_TICK;
            default:             cls.op = rmle_pkg::OP_NONE;
        endcase
        cls.channel = (CHANNELS > 1) ? in_ch.channel : 1'b0;
        cls.rx_byte = in_ch.rx_byte;
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != 2'd0);
    assign q_item      = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

[rtl/rmle_back.sv]
// Back part: channel contexts, shared byte memory and command execution.
// Depends on rmle_pkg; takes queued items and fills a two-entry result buffer.
module rmle_back #(
    parameter int MEM_ADDR_BITS = 16,
    parameter int CHANNELS      = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rmle_pkg::item_t   q_item,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [31:0]       sleep_base,
    input  logic [31:0]       seg_base,
    input  logic [7:0]        timeout_reload,
    rmle_out_if.source        out_ch
);
    localparam int AW = MEM_ADDR_BITS;

    typedef enum logic [1:0] {
        S_FETCH = 2'b01,
        S_EXEC  = 2'b10
    } step_t;

    logic [7:0] mem [2**AW];

    logic [2:0]  rxp_reg [CHANNELS];
    logic [1:0]  txp_reg [CHANNELS];
    logic [7:0]  tick_reg [CHANNELS];
    logic [7:0]  cmd_reg [CHANNELS];
    logic [7:0]  plo_reg [CHANNELS];
    logic [15:0] off_reg [CHANNELS];
    logic [15:0] seg_reg [CHANNELS];
    logic [15:0] sum_reg [CHANNELS];
    logic [31:0] base_reg [CHANNELS];
    logic [31:0] len_reg [CHANNELS];
    logic [31:0] wp_reg [CHANNELS];
    logic [31:0] rp_reg [CHANNELS];
    logic [31:0] wrem_reg [CHANNELS];
    logic [31:0] rrem_reg [CHANNELS];
    logic [15:0] hold_reg [CHANNELS];
    logic        fh_reg [CHANNELS];

    step_t           step_reg;
    logic [7:0]      rd0_reg, rd1_reg;
    logic [AW-1:0]   ra0, ra1;

    rmle_pkg::result_t obuf_reg [2];
    logic              owp_reg, orp_reg;
    logic [1:0]        ocnt_reg;

    logic       ch;
    logic [31:0] addr;

    assign ch   = (CHANNELS > 1) ? q_item.channel : 1'b0;
    assign q_pop = (step_reg == S_EXEC);
    assign addr  = base_reg[ch] + {16'd0, off_reg[ch]};

    always_comb
    begin
        ra0 = addr[AW-1:0];
        ra1 = ra0 + AW'(1);
        if (q_item.op == rmle_pkg::OP_PULL)
        begin
            ra0 = rp_reg[ch][AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    // Execution of one item; all results come from the context of channel ch.
    rmle_pkg::result_t res;
    logic              mwe0, mwe1;
    logic [AW-1:0]     mwa0, mwa1;
    logic [7:0]        mwd0, mwd1;
    logic [2:0]  n_rxp;
    logic [1:0]  n_txp;
    logic [7:0]  n_tick, n_cmd, n_plo, b, ccode, tb;
    logic [15:0] n_off, n_seg, n_sum, n_hold, d;
    logic [31:0] n_base, n_len, n_wp, n_rp, n_wrem, n_rrem;
    logic        n_fh, do_cmd;

    always_comb
    begin
        n_rxp = rxp_reg[ch]; n_txp = txp_reg[ch]; n_tick = tick_reg[ch];
        n_cmd = cmd_reg[ch]; n_plo = plo_reg[ch]; n_off = off_reg[ch];
        n_seg = seg_reg[ch]; n_sum = sum_reg[ch]; n_base = base_reg[ch];
        n_len = len_reg[ch]; n_wp = wp_reg[ch]; n_rp = rp_reg[ch];
        n_wrem = wrem_reg[ch]; n_rrem = rrem_reg[ch]; n_hold = hold_reg[ch];
        n_fh = fh_reg[ch];
        mwe0 = 1'b0; mwe1 = 1'b0; mwa0 = addr[AW-1:0]; mwa1 = addr[AW-1:0] + AW'(1);
        mwd0 = 8'd0; mwd1 = 8'd0;
        res.status = rmle_pkg::ST_ABSORB; res.value = 8'd0;
        b = q_item.rx_byte; do_cmd = 1'b0; ccode = b;
        d = {b, plo_reg[ch]}; tb = 8'd0;
        case (q_item.op)
            rmle_pkg::OP_RX:
            begin
                if (rxp_reg[ch] == rmle_pkg::RX_IDLE)
                begin
                    if (b == rmle_pkg::BYTE_OPEN)
                    begin
                        n_tick = timeout_reload;
                        n_rxp  = rmle_pkg::RX_CMD;
                    end
                    else if (b == rmle_pkg::BYTE_RESUME)
                    begin
                        res.status = rmle_pkg::ST_RESUME;
                    end
                    else if (b == rmle_pkg::HOT_BREAK)
                    begin
                        do_cmd = 1'b1;
                        ccode  = rmle_pkg::CMD_CANCEL;
                    end
                    else
                    begin
                        res.status = rmle_pkg::ST_PASS;
                        res.value  = b;
                    end
                end
                else
                begin
                    n_tick = timeout_reload;
                    case (rxp_reg[ch])
                        rmle_pkg::RX_CMD: do_cmd = 1'b1;
                        rmle_pkg::RX_PLO:
                        begin
                            n_plo = b;
                            n_rxp = rmle_pkg::RX_PHI;
                        end
                        rmle_pkg::RX_PHI:
                        begin
                            n_rxp = rmle_pkg::RX_IDLE;
                            case (cmd_reg[ch])
                                rmle_pkg::CMD_OFFSET: n_off = d;
                                rmle_pkg::CMD_SEGMENT:
                                begin
                                    n_seg  = d;
                                    n_base = (d == 16'd0) ? seg_base : {d, 16'd0};
                                end
                                rmle_pkg::CMD_LEN_LO:
                                begin
                                    n_len = {16'd0, d};
                                    n_sum = d + off_reg[ch] + seg_reg[ch];
                                end
                                rmle_pkg::CMD_LEN_HI: n_len = {d, len_reg[ch][15:0]};
                                rmle_pkg::CMD_WR_BYTE:
                                begin
                                    mwe0 = 1'b1; mwd0 = d[7:0];
                                end
                                rmle_pkg::CMD_WR_WORD:
                                begin
                                    mwe0 = 1'b1; mwd0 = d[7:0];
                                    mwe1 = 1'b1; mwd1 = d[15:8];
                                end
                                default: ;
                            endcase
                        end
                        rmle_pkg::RX_BLK:
                        begin
                            mwe0   = 1'b1; mwa0 = wp_reg[ch][AW-1:0]; mwd0 = b;
                            n_wp   = wp_reg[ch] + 32'd1;
                            n_sum  = sum_reg[ch] + {8'd0, b};
                            n_wrem = wrem_reg[ch] - 32'd1;
                            if (n_wrem == 32'd0)
                            begin
                                n_rxp = rmle_pkg::RX_IDLE;
                            end
                        end
                        default: n_rxp = rmle_pkg::RX_IDLE;
                    endcase
                end
                if (do_cmd)
                begin
                    n_cmd = ccode;
                    n_rxp = rmle_pkg::RX_IDLE;
                    case (ccode)
                        rmle_pkg::CMD_SLEEP:
                        begin
                            n_base = sleep_base; n_off = 16'd0;
                        end
                        rmle_pkg::CMD_BLK_WR:
                        begin
                            n_sum = 16'd0; n_wp = addr; n_wrem = len_reg[ch];
                            n_rxp = rmle_pkg::RX_BLK;
                        end
                        rmle_pkg::CMD_BLK_RD:
                        begin
                            n_rp = addr; n_rrem = len_reg[ch]; n_fh = 1'b0;
                            n_txp = rmle_pkg::TX_LEAD;
                            res.status = rmle_pkg::ST_START;
                        end
                        rmle_pkg::CMD_RD_BYTE, rmle_pkg::CMD_RD_WORD,
                        rmle_pkg::CMD_DUMMY, rmle_pkg::CMD_SUM:
                        begin
                            case (ccode)
                                rmle_pkg::CMD_RD_BYTE: n_hold = {8'd0, rd0_reg};
                                rmle_pkg::CMD_RD_WORD: n_hold = {rd1_reg, rd0_reg};
                                rmle_pkg::CMD_SUM:     n_hold = sum_reg[ch];
                                default:               n_hold = 16'd0;
                            endcase
                            n_fh = 1'b1; n_rp = 32'd0; n_rrem = 32'd2;
                            n_txp = rmle_pkg::TX_LEAD;
                            res.status = rmle_pkg::ST_START;
                        end
                        rmle_pkg::CMD_OFFSET, rmle_pkg::CMD_SEGMENT, rmle_pkg::CMD_LEN_LO,
                        rmle_pkg::CMD_LEN_HI, rmle_pkg::CMD_WR_BYTE, rmle_pkg::CMD_WR_WORD:
                            n_rxp = rmle_pkg::RX_PLO;
                        default: ;
                    endcase
                end
            end
            rmle_pkg::OP_PULL:
            begin
                res.status = rmle_pkg::ST_TXIDLE;
                case (txp_reg[ch])
                    rmle_pkg::TX_IDLE: ;
                    rmle_pkg::TX_LEAD:
                    begin
                        n_sum = 16'd0; n_txp = rmle_pkg::TX_DATA;
                        res.status = rmle_pkg::ST_TXBYTE; res.value = 8'd1;
                    end
                    rmle_pkg::TX_DATA:
                    begin
                        if (fh_reg[ch])
                        begin
                            tb = rp_reg[ch][0] ? hold_reg[ch][15:8] : hold_reg[ch][7:0];
                        end
                        else
                        begin
                            tb = rd0_reg;
                        end
                        n_rp   = rp_reg[ch] + 32'd1;
                        n_sum  = sum_reg[ch] + {8'd0, tb};
                        n_rrem = rrem_reg[ch] - 32'd1;
                        if (n_rrem == 32'd0)
                        begin
                            n_txp = rmle_pkg::TX_IDLE;
                        end
                        res.status = rmle_pkg::ST_TXBYTE; res.value = tb;
                    end
                    default: n_txp = rmle_pkg::TX_IDLE;
                endcase
            end
            rmle_pkg::OP_TICK:
            begin
                res.status = rmle_pkg::ST_TICKOK;
                if (rxp_reg[ch] != rmle_pkg::RX_IDLE)
                begin
                    n_tick = tick_reg[ch] - 8'd1;
                    if (n_tick == 8'd0)
                    begin
                        n_rxp = rmle_pkg::RX_IDLE;
                        res.status = rmle_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == S_EXEC)
        begin
            if (mwe0)
            begin
                mem[mwa0] <= mwd0;
            end
            if (mwe1)
            begin
                mem[mwa1] <= mwd1;
            end
            obuf_reg[owp_reg] <= res;
        end
    end

    assign out_ch.valid  = (ocnt_reg != 2'd0);
    assign out_ch.status = obuf_reg[orp_reg].status;
    assign out_ch.value  = obuf_reg[orp_reg].value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_FETCH;
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                rxp_reg[i] <= '0; txp_reg[i] <= '0; tick_reg[i] <= '0; cmd_reg[i] <= '0;
                plo_reg[i] <= '0; off_reg[i] <= '0; seg_reg[i] <= '0; sum_reg[i] <= '0;
                base_reg[i] <= '0; len_reg[i] <= '0; wp_reg[i] <= '0; rp_reg[i] <= '0;
                wrem_reg[i] <= '0; rrem_reg[i] <= '0; hold_reg[i] <= '0; fh_reg[i] <= '0;
            end
        end
        else
        begin
            case (step_reg)
                S_FETCH:
                begin
                    if (q_valid && ocnt_reg != 2'd2)
                    begin
                        step_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    step_reg <= S_FETCH;
                    owp_reg  <= ~owp_reg;
                    rxp_reg[ch] <= n_rxp; txp_reg[ch] <= n_txp; tick_reg[ch] <= n_tick;
                    cmd_reg[ch] <= n_cmd; plo_reg[ch] <= n_plo; off_reg[ch] <= n_off;
                    seg_reg[ch] <= n_seg; sum_reg[ch] <= n_sum; base_reg[ch] <= n_base;
                    len_reg[ch] <= n_len; wp_reg[ch] <= n_wp; rp_reg[ch] <= n_rp;
                    wrem_reg[ch] <= n_wrem; rrem_reg[ch] <= n_rrem;
                    hold_reg[ch] <= n_hold; fh_reg[ch] <= n_fh;
                end
                default: step_reg <= S_FETCH;
            endcase
            if (out_ch.valid && out_ch.ready)
            begin
                orp_reg <= ~orp_reg;
            end
            ocnt_reg <= ocnt_reg + 2'(step_reg == S_EXEC) - 2'(out_ch.valid && out_ch.ready);
        end
    end
endmodule

[rtl/remote_monitor_link_engine.sv]
// Top level of the remote monitor link engine: configuration registers and the
// front/back split. Depends on rmle_pkg, the interfaces, rmle_front and rmle_back.
//
// Each input item yields exactly one result item. The back part takes each item
// through a fetch step that reads the shared byte memory at the channel's current
// address or read pointer and an execute step that writes memory and channel state.
// A two-entry queue lets the port accept items while an item is executing, and a
// two-entry result buffer lets results wait; once that buffer is full the back part
// stops, the queue fills and the port holds off new items. Items run one at a time.
// The memory has no reset; bytes never written read undefined.
module remote_monitor_link_engine #(
    parameter int MEM_ADDR_BITS = 16,
    parameter int CHANNELS      = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    rmle_in_if.sink     in_ch,
    rmle_out_if.source  out_ch,
    rmle_cfg_if.sink    cfg
);
    logic [31:0]     sleep_base_reg, seg_base_reg;
    logic [7:0]      timeout_reg;
    rmle_pkg::item_t q_item;
    logic            q_valid, q_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_base_reg <= 32'd0;
            seg_base_reg   <= 32'd0;
            timeout_reg    <= 8'd250;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rmle_pkg::CFG_SLEEP:   sleep_base_reg <= cfg.data;
                rmle_pkg::CFG_SEGMENT: seg_base_reg   <= cfg.data;
                rmle_pkg::CFG_TIMEOUT: timeout_reg    <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    rmle_front #(.CHANNELS(CHANNELS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
    );

    rmle_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS), .CHANNELS(CHANNELS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
        .sleep_base(sleep_base_reg), .seg_base(seg_base_reg),
        .timeout_reload(timeout_reg), .out_ch(out_ch)
    );
endmodule

[test/link_engine_checker.sv]
// Checker for the remote monitor link engine: watches the item, result and
// register channels, predicts each result and compares it field by field.
// Depends on rmle_pkg and the channel interfaces.
module link_engine_checker (
    input  logic  clk,
    input  logic  rst_n,
    rmle_in_if    in_ch,
    rmle_out_if   out_ch,
    rmle_cfg_if   cfg,
    output int    fails,
    output int    pending
);

    logic [7:0]  mem [0:65535];
    logic [31:0] sleep_base;
    logic [31:0] dflt_seg;
    logic [7:0]  reload;

    logic [2:0]  rx_ph     [2];
    logic [1:0]  tx_ph     [2];
    logic [7:0]  tick_cnt  [2];
    logic [7:0]  cmd_code  [2];
    logic [7:0]  par_lo    [2];
    logic [15:0] win_off   [2];
    logic [15:0] seg_val   [2];
    logic [15:0] csum      [2];
    logic [31:0] win_base  [2];
    logic [31:0] blk_len   [2];
    logic [31:0] wr_ptr    [2];
    logic [31:0] rd_ptr    [2];
    logic [31:0] wr_left   [2];
    logic [31:0] rd_left   [2];
    logic [15:0] hold_word [2];
    logic        from_hold [2];

    rmle_pkg::result_t awaited_results [$];

    initial
    begin
        for (int i = 0; i < 65536; i++)
            mem[i] = 8'h00;
    end

    function automatic logic [15:0] cur_addr(logic c);
        logic [31:0] a;
        a = win_base[c] + {16'h0, win_off[c]};
        return a[15:0];
    endfunction

    function automatic logic [2:0] run_command(logic c);
        logic [15:0] a;
        logic [15:0] d;
        logic [2:0]  st;
        a = cur_addr(c);
        st = rmle_pkg::ST_ABSORB;
        rx_ph[c] = rmle_pkg::RX_IDLE;
        case (cmd_code[c])
            rmle_pkg::CMD_SLEEP:
            begin
                win_base[c] = sleep_base;
                win_off[c] = 16'h0;
            end
            rmle_pkg::CMD_BLK_WR:
            begin
                csum[c] = 16'h0;
                wr_ptr[c] = win_base[c] + {16'h0, win_off[c]};
                wr_left[c] = blk_len[c];
                rx_ph[c] = rmle_pkg::RX_BLK;
            end
            rmle_pkg::CMD_BLK_RD:
            begin
                rd_ptr[c] = win_base[c] + {16'h0, win_off[c]};
                rd_left[c] = blk_len[c];
                from_hold[c] = 1'b0;
                tx_ph[c] = rmle_pkg::TX_LEAD;
                st = rmle_pkg::ST_START;
            end
            rmle_pkg::CMD_RD_BYTE, rmle_pkg::CMD_RD_WORD, rmle_pkg::CMD_DUMMY,
            rmle_pkg::CMD_SUM:
            begin
                if (cmd_code[c] == rmle_pkg::CMD_RD_BYTE)
                    d = {8'h00, mem[a]};
                else if (cmd_code[c] == rmle_pkg::CMD_RD_WORD)
                    d = {mem[a + 16'd1], mem[a]};
                else if (cmd_code[c] == rmle_pkg::CMD_SUM)
                    d = csum[c];
                else
                    d = 16'h0;
                hold_word[c] = d;
                from_hold[c] = 1'b1;
                rd_ptr[c] = 32'h0;
                rd_left[c] = 32'd2;
                tx_ph[c] = rmle_pkg::TX_LEAD;
                st = rmle_pkg::ST_START;
            end
            rmle_pkg::CMD_OFFSET, rmle_pkg::CMD_SEGMENT, rmle_pkg::CMD_LEN_LO,
            rmle_pkg::CMD_LEN_HI, rmle_pkg::CMD_WR_BYTE, rmle_pkg::CMD_WR_WORD:
                rx_ph[c] = rmle_pkg::RX_PLO;
            default: ;
        endcase
        return st;
    endfunction

    function automatic void apply_param(logic c, logic [15:0] d);
        logic [15:0] a;
        a = cur_addr(c);
        case (cmd_code[c])
            rmle_pkg::CMD_OFFSET: win_off[c] = d;
            rmle_pkg::CMD_SEGMENT:
            begin
                seg_val[c] = d;
                win_base[c] = (d == 16'h0) ? dflt_seg : {d, 16'h0};
            end
            rmle_pkg::CMD_LEN_LO:
            begin
                blk_len[c] = {16'h0, d};
                csum[c] = d + win_off[c] + seg_val[c];
            end
            rmle_pkg::CMD_LEN_HI: blk_len[c] = {d, blk_len[c][15:0]};
            rmle_pkg::CMD_WR_BYTE: mem[a] = d[7:0];
            rmle_pkg::CMD_WR_WORD:
            begin
                mem[a] = d[7:0];
                mem[a + 16'd1] = d[15:8];
            end
            default: ;
        endcase
        rx_ph[c] = rmle_pkg::RX_IDLE;
    endfunction

    function automatic rmle_pkg::result_t next_result(logic [1:0] f, logic c,
                                                       logic [7:0] b);
        rmle_pkg::result_t r;
        logic [7:0] tb;
        r.status = rmle_pkg::ST_ABSORB;
        r.value = 8'h00;
        if (f == rmle_pkg::FUNC_RX)
        begin
            if (rx_ph[c] == rmle_pkg::RX_IDLE)
            begin
                if (b == rmle_pkg::BYTE_OPEN)
                begin
                    tick_cnt[c] = reload;
                    rx_ph[c] = rmle_pkg::RX_CMD;
                end
                else if (b == rmle_pkg::BYTE_RESUME)
                    r.status = rmle_pkg::ST_RESUME;
                else if (b == rmle_pkg::HOT_BREAK)
                begin
                    cmd_code[c] = rmle_pkg::CMD_CANCEL;
                    r.status = run_command(c);
                end
                else
                begin
                    r.status = rmle_pkg::ST_PASS;
                    r.value = b;
                end
            end
            else
            begin
                tick_cnt[c] = reload;
                case (rx_ph[c])
                    rmle_pkg::RX_CMD:
                    begin
                        cmd_code[c] = b;
                        r.status = run_command(c);
                    end
                    rmle_pkg::RX_PLO:
                    begin
                        par_lo[c] = b;
                        rx_ph[c] = rmle_pkg::RX_PHI;
                    end
                    rmle_pkg::RX_PHI: apply_param(c, {b, par_lo[c]});
                    rmle_pkg::RX_BLK:
                    begin
                        mem[wr_ptr[c][15:0]] = b;
                        wr_ptr[c] = wr_ptr[c] + 32'd1;
                        csum[c] = csum[c] + {8'h00, b};
                        wr_left[c] = wr_left[c] - 32'd1;
                        if (wr_left[c] == 32'h0)
                            rx_ph[c] = rmle_pkg::RX_IDLE;
                    end
                    default: rx_ph[c] = rmle_pkg::RX_IDLE;
                endcase
            end
        end
        else if (f == rmle_pkg::FUNC_PULL)
        begin
            r.status = rmle_pkg::ST_TXBYTE;
            case (tx_ph[c])
                rmle_pkg::TX_IDLE: r.status = rmle_pkg::ST_TXIDLE;
                rmle_pkg::TX_LEAD:
                begin
                    csum[c] = 16'h0;
                    tx_ph[c] = rmle_pkg::TX_DATA;
                    r.value = 8'h01;
                end
                rmle_pkg::TX_DATA:
                begin
                    if (from_hold[c])
                        tb = rd_ptr[c][0] ? hold_word[c][15:8] : hold_word[c][7:0];
                    else
                        tb = mem[rd_ptr[c][15:0]];
                    rd_ptr[c] = rd_ptr[c] + 32'd1;
                    csum[c] = csum[c] + {8'h00, tb};
                    rd_left[c] = rd_left[c] - 32'd1;
                    if (rd_left[c] == 32'h0)
                        tx_ph[c] = rmle_pkg::TX_IDLE;
                    r.value = tb;
                end
                default:
                begin
                    tx_ph[c] = rmle_pkg::TX_IDLE;
                    r.status = rmle_pkg::ST_TXIDLE;
                end
            endcase
        end
        else if (f == rmle_pkg::FUNC_TICK)
        begin
            r.status = rmle_pkg::ST_TICKOK;
            if (rx_ph[c] != rmle_pkg::RX_IDLE)
            begin
                tick_cnt[c] = tick_cnt[c] - 8'd1;
                if (tick_cnt[c] == 8'h0)
                begin
                    rx_ph[c] = rmle_pkg::RX_IDLE;
                    r.status = rmle_pkg::ST_TIMEOUT;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rmle_pkg::result_t want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            sleep_base <= 32'h0;
            dflt_seg <= 32'h0;
            reload <= 8'd250;
            fails <= 0;
            pending <= 0;
            awaited_results.delete();
            for (int i = 0; i < 2; i++)
            begin
                rx_ph[i] = rmle_pkg::RX_IDLE;
                tx_ph[i] = rmle_pkg::TX_IDLE;
                tick_cnt[i] = 8'h0;
                cmd_code[i] = 8'h0;
                par_lo[i] = 8'h0;
                win_off[i] = 16'h0;
                seg_val[i] = 16'h0;
                csum[i] = 16'h0;
                win_base[i] = 32'h0;
                blk_len[i] = 32'h0;
                wr_ptr[i] = 32'h0;
                rd_ptr[i] = 32'h0;
                wr_left[i] = 32'h0;
                rd_left[i] = 32'h0;
                hold_word[i] = 16'h0;
                from_hold[i] = 1'b0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    rmle_pkg::CFG_SLEEP: sleep_base <= cfg.data;
                    rmle_pkg::CFG_SEGMENT: dflt_seg <= cfg.data;
                    rmle_pkg::CFG_TIMEOUT: reload <= cfg.data[7:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                awaited_results.push_back(next_result(in_ch.func, in_ch.channel,
                                                      in_ch.rx_byte));
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no item waiting: status %0d value %0h",
                           out_ch.status, out_ch.value);
                    errs++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        errs++;
                    end
                    if (out_ch.value !== want.value)
                    begin
                        $error("value: expected %0h, got %0h", want.value, out_ch.value);
                        errs++;
                    end
                end
            end
            fails <= fails + errs;
            pending <= awaited_results.size();
        end
    end

endmodule

[test/tb_top.sv]
// Testbench top for the remote monitor link engine: preloads the memory, then
// runs directed and random command traffic under several register settings.
// Depends on rmle_pkg, the channel interfaces, link_engine_checker and the RTL.
module tb_top;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   offered;
    int   burst_left;
    int   idle_cycles;
    logic hold_req;

    rmle_in_if  in_ch ();
    rmle_out_if out_ch ();
    rmle_cfg_if cfg_ch ();

    remote_monitor_link_engine u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    link_engine_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg     (cfg_ch),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int run;
        int style;
        out_ch.ready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 30);
            style = $urandom_range(0, 2);
            repeat (run)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    out_ch.ready <= 1'b0;
                    repeat (400) @(posedge clk);
                end
                if (style == 0)
                    out_ch.ready <= 1'b1;
                else if (style == 1)
                    out_ch.ready <= 1'($urandom_range(0, 1));
                else
                    out_ch.ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic send_item(logic [1:0] f, logic c, logic [7:0] b);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.channel <= c;
        in_ch.rx_byte <= b;
        offered++;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic rx(logic c, logic [7:0] b);
        send_item(rmle_pkg::FUNC_RX, c, b);
    endtask

    task automatic pulls(logic c, int n);
        repeat (n) send_item(rmle_pkg::FUNC_PULL, c, 8'($urandom_range(0, 255)));
    endtask

    task automatic ticks(logic c, int n);
        repeat (n) send_item(rmle_pkg::FUNC_TICK, c, 8'($urandom_range(0, 255)));
    endtask

    task automatic command(logic c, logic [7:0] code);
        rx(c, rmle_pkg::BYTE_OPEN);
        rx(c, code);
    endtask

    task automatic param(logic c, logic [7:0] code, logic [15:0] w);
        command(c, code);
        rx(c, w[7:0]);
        rx(c, w[15:8]);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_command(logic c);
        logic [7:0] sel;
        case ($urandom_range(0, 15))
            0: param(c, rmle_pkg::CMD_OFFSET, 16'($urandom_range(0, 65535)));
            1: param(c, rmle_pkg::CMD_SEGMENT,
                     $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'd0);
            2:
            begin
                param(c, rmle_pkg::CMD_LEN_LO, 16'($urandom_range(0, 12)));
                param(c, rmle_pkg::CMD_LEN_HI, ($urandom_range(0, 19) == 0) ? 16'd1 : 16'd0);
            end
            3: param(c, rmle_pkg::CMD_WR_BYTE, 16'($urandom_range(0, 65535)));
            4: param(c, rmle_pkg::CMD_WR_WORD, 16'($urandom_range(0, 65535)));
            5:
            begin
                command(c, rmle_pkg::CMD_BLK_WR);
                repeat ($urandom_range(0, 14)) rx(c, 8'($urandom_range(0, 255)));
            end
            6:
            begin
                command(c, rmle_pkg::CMD_BLK_RD);
                pulls(c, int'($urandom_range(0, 14)));
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0: sel = rmle_pkg::CMD_RD_BYTE;
                    1: sel = rmle_pkg::CMD_RD_WORD;
                    2: sel = rmle_pkg::CMD_DUMMY;
                    default: sel = rmle_pkg::CMD_SUM;
                endcase
                command(c, sel);
                pulls(c, 3);
            end
            8: command(c, rmle_pkg::CMD_SLEEP);
            9: command(c, 8'($urandom_range(0, 255)));
            10: ticks(c, int'($urandom_range(1, 6)));
            11: pulls(c, int'($urandom_range(1, 3)));
            12: rx(c, 8'($urandom_range(0, 255)));
            13: send_item(FUNC_UNUSED, c, 8'($urandom_range(0, 255)));
            14: rx(c, $urandom_range(0, 1) ? rmle_pkg::HOT_BREAK : rmle_pkg::BYTE_RESUME);
            default: param(c, rmle_pkg::CMD_OFFSET, 16'($urandom_range(0, 15)));
        endcase
    endtask

    initial
    begin
        logic [31:0] sleep_vals [6];
        logic [31:0] seg_vals [6];
        logic [7:0]  reload_vals [6];
        int target;
        sleep_vals = '{32'h0, 32'hFFFF_FFFF, 32'h0001_2345, 32'h0, 32'h8000_7FFF, 32'h0};
        seg_vals = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0000_FF00, 32'h1234_5678, 32'h0};
        reload_vals = '{8'd250, 8'd1, 8'd255, 8'd3, 8'd2, 8'd5};
        // Preload the memory so that every read returns a defined byte.
        for (int i = 0; i < 65536; i++)
            u_top.u_back.mem[i] = 8'h00;
        rst_n = 1'b0;
        hold_req = 1'b0;
        offered = 0;
        burst_left = 0;
        idle_cycles = 0;
        in_ch.valid = 1'b0;
        in_ch.func = rmle_pkg::FUNC_RX;
        in_ch.channel = 1'b0;
        in_ch.rx_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = rmle_pkg::CFG_SLEEP;
        cfg_ch.data = 32'h0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rx(1'b0, 8'hFF);
        rx(1'b1, 8'h7E);
        rx(1'b0, rmle_pkg::BYTE_RESUME);
        rx(1'b1, rmle_pkg::HOT_BREAK);
        send_item(FUNC_UNUSED, 1'b1, 8'hFF);
        ticks(1'b0, 1);
        pulls(1'b1, 1);
        param(1'b1, rmle_pkg::CMD_OFFSET, 16'hFFFF);
        param(1'b1, rmle_pkg::CMD_WR_WORD, 16'hA55A);
        command(1'b1, rmle_pkg::CMD_RD_WORD);
        pulls(1'b1, 3);
        command(1'b0, rmle_pkg::CMD_DUMMY);
        pulls(1'b0, 2);
        command(1'b0, 8'hFF);
        settle();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(rmle_pkg::CFG_SLEEP, sleep_vals[p]);
            write_reg(rmle_pkg::CFG_SEGMENT, seg_vals[p]);
            write_reg(rmle_pkg::CFG_TIMEOUT, {24'h0, reload_vals[p]});
            if (p == 3)
            begin
                // Zero-length block write runs until the tick timeout ends it.
                param(1'b0, rmle_pkg::CMD_LEN_LO, 16'h0);
                param(1'b0, rmle_pkg::CMD_LEN_HI, 16'h0);
                command(1'b0, rmle_pkg::CMD_BLK_WR);
                repeat (5) rx(1'b0, 8'($urandom_range(0, 255)));
                ticks(1'b0, 4);
                command(1'b1, rmle_pkg::CMD_SUM);
                pulls(1'b1, 3);
            end
            if (p == 2)
                hold_req = 1'b1;
            target = offered + 115;
            while (offered < target)
                random_command(1'($urandom_range(0, 1)));
            settle();
        end

        if (fails == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/rmle_pkg.sv
rtl/rmle_if.sv
rtl/rmle_front.sv
rtl/rmle_back.sv
rtl/remote_monitor_link_engine.sv
test/link_engine_checker.sv
test/tb_top.sv
